// ===== hw/rtl/pancake_sort_flip_sequencer_top_macros.svh =====
// Assertion macros used by the pancake-sort flip sequencer checker.
`ifndef PANCAKE_SORT_FLIP_SEQUENCER_TOP_MACROS_SVH
`define PANCAKE_SORT_FLIP_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled in reset.
`define PSSF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled in reset.
`define PSSF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/pssf_pkg.sv =====
// Package with types and constants of the pancake-sort flip sequencer.
package pssf_pkg;

   // Width of the value field of an input item.
   localparam int VALUE_IN_W = 16;
   // Width of the flip position field of a result item.
   localparam int FLIP_W = 6;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT_BIG,
      ST_EMIT_TGT,
      ST_FLIP_RD,
      ST_FLIP_WLO,
      ST_FLIP_WHI,
      ST_NEXT,
      ST_FINAL
   } state_type;

endpackage

// ===== hw/rtl/pssf_req_if.sv =====
// Handshake interfaces for the input and result channels.
interface pssf_req_if;
   import pssf_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_IN_W-1:0] value;
   logic                         bottom;
   modport source (output valid, output value, output bottom, input ready);
   modport sink (input valid, input value, input bottom, output ready);
endinterface

interface pssf_rsp_if;
   import pssf_pkg::*;
   logic              valid;
   logic              ready;
   logic [FLIP_W-1:0] flip_position;
   logic              last;
   modport source (output valid, output flip_position, output last, input ready);
   modport sink (input valid, input flip_position, input last, output ready);
endinterface

// ===== hw/rtl/pancake_sort_flip_sequencer_top.sv =====
// Top level of the pancake-sort flip sequencer.
//
//   Channel   Dir  Fields                         Handshake
//   req_ch    in   value (16b signed), bottom     valid/ready
//   rsp_ch    out  flip_position (6b), last       valid/ready
//
// While loading, an item is taken whenever one is offered; the item flagged bottom closes
// the stack and starts a sort on one shared compare unit and a dual-read stack RAM. A pass
// over a prefix ending at index t scans it, decides, emits each result, performs each flip
// as element swaps (read, write low, write high) and steps to the next pass.
// Reset is synchronous and active high; the stack RAM needs no clearing.
// While the result register is full and not taken, the sequencer waits before emitting a result.
module pancake_sort_flip_sequencer_top #(
   parameter int MAX_STACK  = 32,
   parameter int VALUE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   pssf_req_if.sink          req_ch,
   pssf_rsp_if.source        rsp_ch
);
   import pssf_pkg::*;

   // Index width for the stack, and count width that can also hold the depth.
   localparam int IDX_W = $clog2(MAX_STACK);
   localparam int CNT_W = $clog2(MAX_STACK + 1);
   // Common width for turning the input field into a stored element.
   localparam int EXT_W = (VALUE_BITS > VALUE_IN_W) ? VALUE_BITS : VALUE_IN_W;

   state_type state_ff, state_in;

   // Stack bookkeeping: count is also the stack size during a sort.
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] tgt_ff, tgt_in;

   // Scan of the unsorted prefix: read issue side and data side.
   logic [IDX_W-1:0]      saddr_ff, saddr_in;
   logic                  issue_ff, issue_in;
   logic                  dv_ff, dv_in;
   logic [IDX_W-1:0]      didx_ff, didx_in;
   logic                  dlast_ff, dlast_in;
   logic [VALUE_BITS-1:0] prev_ff, prev_in;
   logic [VALUE_BITS-1:0] best_ff, best_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic                  sorted_ff, sorted_in;

   // Prefix reversal: two pointers walking toward each other.
   logic [IDX_W-1:0]      lo_ff, lo_in;
   logic [IDX_W-1:0]      hi_ff, hi_in;
   logic                  pass2_ff, pass2_in;
   logic [VALUE_BITS-1:0] hold_ff, hold_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [FLIP_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic              rsp_last_ff, rsp_last_in;

   // Stack RAM ports.
   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic [VALUE_BITS-1:0] ram_wdata;
   logic [IDX_W-1:0]      ram_raddr_a;
   logic [IDX_W-1:0]      ram_raddr_b;
   logic [VALUE_BITS-1:0] ram_rdata_a;
   logic [VALUE_BITS-1:0] ram_rdata_b;

   logic                  accept;
   logic                  room;
   logic [CNT_W-1:0]      new_count;
   logic                  out_free;
   logic [EXT_W-1:0]      value_ext;
   logic [VALUE_BITS-1:0] value_store;

   pssf_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_STACK)
   ) u_stack_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_addr_a (ram_raddr_a),
      .rd_data_a (ram_rdata_a),
      .rd_addr_b (ram_raddr_b),
      .rd_data_b (ram_rdata_b)
   );

   // The element is the low VALUE_BITS bits of the field, read as signed.
   assign value_ext   = EXT_W'($unsigned(req_ch.value));
   assign value_store = value_ext[VALUE_BITS-1:0];

   assign accept    = req_ch.valid && req_ch.ready;
   assign room      = count_ff < CNT_W'(MAX_STACK);
   assign new_count = room ? count_ff + CNT_W'(1) : count_ff;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept && req_ch.bottom) begin
               // A single element is already sorted.
               state_in = (new_count <= CNT_W'(1)) ? ST_FINAL : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (dv_ff && dlast_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (sorted_ff) begin
               state_in = ST_FINAL;
            end else if (best_idx_ff == '0) begin
               state_in = ST_EMIT_TGT;
            end else if (best_idx_ff == tgt_ff) begin
               state_in = ST_NEXT;
            end else begin
               state_in = ST_EMIT_BIG;
            end
         end
         ST_EMIT_BIG, ST_EMIT_TGT: begin
            if (out_free) begin
               state_in = ST_FLIP_RD;
            end
         end
         ST_FLIP_RD: begin
            priority if (lo_ff < hi_ff) begin
               state_in = ST_FLIP_WLO;
            end else if (pass2_ff) begin
               state_in = ST_NEXT;
            end else begin
               state_in = ST_EMIT_TGT;
            end
         end
         ST_FLIP_WLO: state_in = ST_FLIP_WHI;
         ST_FLIP_WHI: state_in = ST_FLIP_RD;
         ST_NEXT: begin
            state_in = (tgt_ff == IDX_W'(1)) ? ST_FINAL : ST_SCAN;
         end
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Outputs toward the channels and the stack RAM.
   always_comb begin
      req_ch.ready = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = lo_ff;
      ram_wdata    = ram_rdata_b;
      ram_raddr_a  = saddr_ff;
      ram_raddr_b  = hi_ff;
      unique case (state_ff)
         ST_LOAD: begin
            // Ready is always high while loading, so valid alone marks an accepted item.
            req_ch.ready = 1'b1;
            ram_we       = req_ch.valid && room;
            ram_waddr    = count_ff[IDX_W-1:0];
            ram_wdata    = value_store;
         end
         ST_FLIP_RD: begin
            ram_raddr_a = lo_ff;
            ram_raddr_b = hi_ff;
         end
         ST_FLIP_WLO: begin
            // The element from the high end goes to the low end.
            ram_we    = 1'b1;
            ram_waddr = lo_ff;
            ram_wdata = ram_rdata_b;
         end
         ST_FLIP_WHI: begin
            ram_we    = 1'b1;
            ram_waddr = hi_ff;
            ram_wdata = hold_ff;
         end
         default: begin
         end
      endcase
   end

   // Datapath registers.
   always_comb begin
      count_in     = count_ff;
      tgt_in       = tgt_ff;
      saddr_in     = saddr_ff;
      issue_in     = issue_ff;
      dv_in        = 1'b0;
      didx_in      = didx_ff;
      dlast_in     = dlast_ff;
      prev_in      = prev_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      sorted_in    = sorted_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      pass2_in     = pass2_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               count_in = new_count;
               if (req_ch.bottom) begin
                  // The first pass covers the whole stack.
                  tgt_in   = IDX_W'(new_count - CNT_W'(1));
                  saddr_in = '0;
                  issue_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff) begin
               dv_in    = 1'b1;
               didx_in  = saddr_ff;
               dlast_in = saddr_ff == tgt_ff;
               saddr_in = saddr_ff + IDX_W'(1);
               issue_in = saddr_ff != tgt_ff;
            end
            if (dv_ff) begin
               // One compare unit keeps the order check and the first maximum.
               if (didx_ff == '0) begin
                  best_in     = ram_rdata_a;
                  best_idx_in = '0;
                  sorted_in   = 1'b1;
               end else begin
                  if ($signed(ram_rdata_a) < $signed(prev_ff)) begin
                     sorted_in = 1'b0;
                  end
                  if ($signed(ram_rdata_a) > $signed(best_ff)) begin
                     best_in     = ram_rdata_a;
                     best_idx_in = didx_ff;
                  end
               end
               prev_in = ram_rdata_a;
            end
         end
         ST_EMIT_BIG: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = FLIP_W'(count_ff - CNT_W'(best_idx_ff));
               rsp_last_in  = 1'b0;
               lo_in        = '0;
               hi_in        = best_idx_ff;
               pass2_in     = 1'b0;
            end
         end
         ST_EMIT_TGT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = FLIP_W'(count_ff - CNT_W'(tgt_ff));
               rsp_last_in  = 1'b0;
               lo_in        = '0;
               hi_in        = tgt_ff;
               pass2_in     = 1'b1;
            end
         end
         ST_FLIP_WLO: begin
            hold_in = ram_rdata_a;
         end
         ST_FLIP_WHI: begin
            lo_in = lo_ff + IDX_W'(1);
            hi_in = hi_ff - IDX_W'(1);
         end
         ST_NEXT: begin
            tgt_in   = tgt_ff - IDX_W'(1);
            saddr_in = '0;
            issue_in = 1'b1;
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = '0;
               rsp_last_in  = 1'b1;
               count_in     = '0;
               tgt_in       = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         tgt_ff       <= '0;
         issue_ff     <= 1'b0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tgt_ff       <= tgt_in;
         issue_ff     <= issue_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      saddr_ff    <= saddr_in;
      didx_ff     <= didx_in;
      dlast_ff    <= dlast_in;
      prev_ff     <= prev_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      sorted_ff   <= sorted_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      pass2_ff    <= pass2_in;
      hold_ff     <= hold_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.flip_position = rsp_pos_ff;
   assign rsp_ch.last          = rsp_last_ff;

endmodule

// ===== hw/rtl/pssf_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
module pssf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hw/rtl/pssf_checker.sv =====
// Port-level checker for the pancake-sort flip sequencer, bound to the top level.
`include "pancake_sort_flip_sequencer_top_macros.svh"

module pssf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_bottom,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [pssf_pkg::FLIP_W-1:0] rsp_flip_position,
   input logic                        rsp_last
);
   import pssf_pkg::*;

   // A result that is not taken stays offered unchanged.
   `PSSF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_flip_position) && $stable(rsp_last), "result changed while stalled")
   // The closing result always reports position zero.
   `PSSF_ASSERT_NOW(a_last_zero, rsp_valid && rsp_last, rsp_flip_position == '0, "last result is not zero")
   // Every flip lies at position one or above.
   `PSSF_ASSERT_NOW(a_flip_nonzero, rsp_valid && !rsp_last, rsp_flip_position != '0, "flip at position zero")
   // Closing the stack starts a sort, during which no item is taken.
   `PSSF_ASSERT_NEXT(a_busy_after_bottom, req_valid && req_ready && req_bottom, !req_ready, "ready right after the bottom item")

endmodule

bind pancake_sort_flip_sequencer_top pssf_checker u_pssf_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .req_bottom        (req_ch.bottom),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_flip_position (rsp_ch.flip_position),
   .rsp_last          (rsp_ch.last)
);

// ===== sim/pancake_sort_flip_sequencer_top_tb.sv =====
// Self-checking testbench for the pancake-sort flip sequencer top level.
module pancake_sort_flip_sequencer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pssf_pkg::*;

   // The stack depth that the block is built with here. The predictor keeps the same depth.
   localparam int STACK_DEPTH = 32;
   // The random part stops once this many items have been offered after the directed part.
   localparam int RANDOM_ITEMS = 240;
   // This is the chance, in percent, that each side idles while idling is enabled.
   localparam int IDLE_PCT = 31;
   // This is how long the receiver holds off, in cycles, when it is asked to.
   localparam int HOLD_OFF_CYCLES = 400;
   // After the last expected result has arrived, the run waits this many cycles for stray results.
   localparam int DRAIN_CYCLES = 60;
   // Only this many mismatches are reported in detail. Later ones are counted.
   localparam int SHOWN_ERRORS = 10;

   typedef struct packed {
      logic [FLIP_W-1:0] flip_position;
      logic              last;
   } flip_result_type;

   // This is one row of the directed table. Where typed is set, the results of the row are
   // written out in the table: an optional flip, followed by the terminating zero.
   typedef struct {
      logic signed [VALUE_IN_W-1:0] value;
      logic                         bottom;
      bit                           typed;
      bit                           has_flip;
      logic [FLIP_W-1:0]            flip_pos;
   } stack_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pssf_req_if req_ch ();
   pssf_rsp_if rsp_ch ();

   pancake_sort_flip_sequencer_top #(
      .MAX_STACK  (STACK_DEPTH),
      .VALUE_BITS (VALUE_IN_W)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // The clock has a period of 12 ns. Inputs change on the falling edge, and outputs are
   // sampled on the rising edge.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // This is the predictor's own copy of the stack. Only the entries of the current stack
   // are ever read.
   logic signed [VALUE_IN_W-1:0] stack_vals [STACK_DEPTH];
   int                           stack_depth = 0;

   flip_result_type flips_predicted [$];  // These are the flips caused by the last accepted item.
   flip_result_type typed_flips [$];      // These results are typed in for the current table row.
   flip_result_type expected_flips [$];   // These results are still waiting to arrive.

   int  mismatch_count = 0;
   bit  steady = 1'b0;         // When this is set, neither side idles.
   bit  hold_off_req = 1'b0;   // This asks the receiver for one long hold-off.
   int  hold_left = 0;
   int  random_items = 0;

   stack_row_type directed_rows [21];

   function automatic flip_result_type make_flip(input int pos, input logic last);
      flip_result_type r;
      r.flip_position = FLIP_W'(pos);
      r.last          = last;
      return r;
   endfunction

   function automatic bit stack_in_order(input int n);
      for (int i = 1; i < n; i++) begin
         if (stack_vals[i] < stack_vals[i-1]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // This reverses the top of the stack, from index 0 through index hi.
   function automatic void reverse_top(input int hi);
      int                           lo;
      logic signed [VALUE_IN_W-1:0] t;
      lo = 0;
      while (lo < hi) begin
         t              = stack_vals[lo];
         stack_vals[lo] = stack_vals[hi];
         stack_vals[hi] = t;
         lo++;
         hi--;
      end
   endfunction

   // This function loads one item into the predicted stack. When the item closes the stack,
   // the function sorts the stack and leaves the flips that the block must report in
   // flips_predicted. A value that arrives on a full stack is dropped. A value that arrives
   // on a full stack with bottom set still starts the sort.
   function automatic void stack_item(input logic signed [VALUE_IN_W-1:0] v, input logic b);
      int size;
      int tgt;
      int big;
      flips_predicted.delete();
      if (stack_depth < STACK_DEPTH) begin
         stack_vals[stack_depth] = v;
         stack_depth++;
      end
      if (!b) begin
         return;
      end
      size = stack_depth;
      tgt  = size - 1;
      while (tgt >= 1 && !stack_in_order(size)) begin
         big = 0;
         for (int i = 1; i <= tgt; i++) begin
            if (stack_vals[i] > stack_vals[big]) begin
               big = i;
            end
         end
         if (big == 0) begin
            // The largest value is already on top, so a single flip puts it in place.
            flips_predicted.insert(flips_predicted.size(), make_flip(size - tgt, 1'b0));
            reverse_top(tgt);
         end else if (big != tgt) begin
            reverse_top(big);
            flips_predicted.insert(flips_predicted.size(), make_flip(size - big, 1'b0));
            reverse_top(tgt);
            flips_predicted.insert(flips_predicted.size(), make_flip(size - tgt, 1'b0));
         end
         tgt--;
      end
      flips_predicted.insert(flips_predicted.size(), make_flip(0, 1'b1));
      stack_depth = 0;
   endfunction

   // This task offers one item and waits until it is accepted. It is entered on a falling edge
   // and returns on a falling edge. The valid signal stays high on return, so the next call can
   // either change the item or lower valid, with only one assignment in that time step.
   task automatic offer_item(input logic signed [VALUE_IN_W-1:0] v, input logic b);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.value  <= v;
      req_ch.bottom <= b;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      // The item is accepted on this edge. Its results are queued now, before any of them
      // can appear.
      stack_item(v, b);
      if (typed_flips.size() > 0) begin
         foreach (typed_flips[i]) expected_flips.insert(expected_flips.size(), typed_flips[i]);
      end else begin
         foreach (flips_predicted[i]) begin
            expected_flips.insert(expected_flips.size(), flips_predicted[i]);
         end
      end
      typed_flips.delete();
      @(negedge clock);
   endtask

   // This function draws one stack value. The flavor selects the kind of value: fully random,
   // a narrow band with many duplicates, a descending ramp, or the extremes.
   function automatic logic signed [VALUE_IN_W-1:0] pick_value(input int flavor, input int idx,
                                                               input int size);
      case (flavor)
         0: return VALUE_IN_W'($urandom);
         1: return VALUE_IN_W'(int'($urandom_range(6)) - 3);
         2: return VALUE_IN_W'((size - idx) * 97 - 1000);
         default: begin
            case ($urandom_range(3))
               0: return VALUE_IN_W'(-32768);
               1: return VALUE_IN_W'(32767);
               2: return VALUE_IN_W'(0);
               default: return VALUE_IN_W'(-1);
            endcase
         end
      endcase
   endfunction

   function automatic void note_mismatch(input string what, input flip_result_type want,
                                         input flip_result_type got);
      mismatch_count++;
      if (mismatch_count <= SHOWN_ERRORS) begin
         $display("mismatch (%s) at %0t: expected pos=%0d last=%0b, got pos=%0d last=%0b",
                  what, $realtime, want.flip_position, want.last, got.flip_position, got.last);
      end
   endfunction

   // The receiver drives ready on the falling edge. It idles at random, except during the
   // steady stretch. On request, it holds ready low for a long stretch, which it counts itself.
   // Meanwhile the sender keeps offering items, so the result register fills and the block
   // stalls its input.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else if (hold_off_req) begin
         rsp_ch.ready <= 1'b0;
         hold_left    = HOLD_OFF_CYCLES - 1;
         hold_off_req = 1'b0;
      end else begin
         rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Each accepted result is compared with the oldest expectation, field by field.
   always @(posedge clock) begin
      flip_result_type got;
      flip_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.flip_position = rsp_ch.flip_position;
         got.last          = rsp_ch.last;
         if (expected_flips.size() == 0) begin
            note_mismatch("no result expected", make_flip(0, 1'b0), got);
         end else begin
            want = expected_flips.pop_front();
            if (got.flip_position !== want.flip_position || got.last !== want.last) begin
               note_mismatch("wrong field", want, got);
            end
         end
      end
   end

   // This is the overall time limit. It lies far beyond the slowest correct run.
   initial begin
      #5ms;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int size;
      int flavor;
      int r;
      int stack_no;

      req_ch.valid  = 1'b0;
      req_ch.value  = '0;
      req_ch.bottom = 1'b0;

      // The directed table. A single element gives only the terminating zero. A reversed pair
      // needs one flip, at position 1. Sorted stacks and stacks of equal values need no flip.
      // The untyped rows are checked against the predictor. They cover a first largest value
      // that occurs twice, a largest value that is already in place, a largest value in the
      // middle of the stack, and a reversed stack of extremes.
      directed_rows = '{
         '{-32768, 1'b1, 1'b1, 1'b0, 6'd0},
         '{ 32767, 1'b0, 1'b0, 1'b0, 6'd0},
         '{-32768, 1'b1, 1'b1, 1'b1, 6'd1},
         '{    -1, 1'b0, 1'b0, 1'b0, 6'd0},
         '{     0, 1'b1, 1'b1, 1'b0, 6'd0},
         '{     5, 1'b0, 1'b0, 1'b0, 6'd0},
         '{     5, 1'b0, 1'b0, 1'b0, 6'd0},
         '{     5, 1'b1, 1'b1, 1'b0, 6'd0},
         '{     7, 1'b0, 1'b0, 1'b0, 6'd0},
         '{     3, 1'b0, 1'b0, 1'b0, 6'd0},
         '{     7, 1'b0, 1'b0, 1'b0, 6'd0},
         '{     1, 1'b1, 1'b0, 1'b0, 6'd0},
         '{     2, 1'b0, 1'b0, 1'b0, 6'd0},
         '{     1, 1'b0, 1'b0, 1'b0, 6'd0},
         '{     9, 1'b1, 1'b0, 1'b0, 6'd0},
         '{     1, 1'b0, 1'b0, 1'b0, 6'd0},
         '{     9, 1'b0, 1'b0, 1'b0, 6'd0},
         '{     2, 1'b1, 1'b0, 1'b0, 6'd0},
         '{ 32767, 1'b0, 1'b0, 1'b0, 6'd0},
         '{     0, 1'b0, 1'b0, 1'b0, 6'd0},
         '{-32768, 1'b1, 1'b0, 1'b0, 6'd0}
      };

      // Reset is released on a falling edge.
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].typed) begin
            if (directed_rows[i].has_flip) begin
               typed_flips.insert(typed_flips.size(), make_flip(directed_rows[i].flip_pos, 1'b0));
            end
            typed_flips.insert(typed_flips.size(), make_flip(0, 1'b1));
         end
         offer_item(directed_rows[i].value, directed_rows[i].bottom);
      end

      // The random part consists of whole stacks. Most stacks are small. A few fill the block,
      // and a few overflow it, so that the closing item itself is dropped. The second stack is
      // always full, and the receiver holds off just before that stack closes. One stretch of
      // stacks runs with no idling on either side.
      stack_no = 0;
      while (random_items < RANDOM_ITEMS) begin
         r = $urandom_range(99);
         if (stack_no == 1) begin
            size = STACK_DEPTH;
         end else if (r < 70) begin
            size = $urandom_range(1, 8);
         end else if (r < 86) begin
            size = $urandom_range(9, STACK_DEPTH - 1);
         end else if (r < 93) begin
            size = STACK_DEPTH;
         end else begin
            size = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 3);
         end
         flavor = (stack_no == 1) ? 0 : $urandom_range(3);
         steady = (stack_no >= 10 && stack_no < 18);
         for (int k = 0; k < size; k++) begin
            if (stack_no == 1 && k == size - 1) begin
               hold_off_req = 1'b1;
            end
            offer_item(pick_value(flavor, k, size), k == size - 1);
            random_items++;
         end
         stack_no++;
      end
      req_ch.valid <= 1'b0;
      steady = 1'b0;

      while (expected_flips.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_flips.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
